/* rtl/bpms_pkg.sv */
`default_nettype none

package bpms_pkg;

   // needle storage is fixed by the four 64-bit needle words
   localparam int NEEDLE_SLOTS   = 32;
   localparam int LEN_BITS       = 6;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int MATCH_BITS     = 32;

   // needles at least this long with two or fewer byte values resume past the match
   localparam logic [LEN_BITS-1:0] LOW_ENTROPY_MIN_LEN = 6'd16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_WORD_0 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_WORD_1 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_WORD_2 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_WORD_3 = 3'd4;

   // needle view prepared for the scan stage
   typedef struct packed {
      logic [LEN_BITS-1:0]               len;          // clipped length in use
      logic                              all_same;     // every needle byte equal
      logic                              low_entropy;  // long needle, at most two values
      logic [7:0]                        first_byte;   // needle byte 0
      logic [NEEDLE_SLOTS-1:0][7:0]      aligned;      // slot j holds needle byte len-1-j
   } needle_class_type;

endpackage

`default_nettype wire

/* rtl/bpms_needle.sv */
`default_nettype none

module bpms_needle #(
   parameter int MAX_NEEDLE_BYTES = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write,
   input  wire logic [bpms_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [bpms_pkg::CSR_DATA_BITS-1:0]     csr_data,
   output bpms_pkg::needle_class_type                  needle_class
);

   localparam logic [bpms_pkg::LEN_BITS-1:0] LEN_LIMIT =
      bpms_pkg::LEN_BITS'(MAX_NEEDLE_BYTES);

   logic [bpms_pkg::LEN_BITS-1:0]                  length_ff, length_in;
   logic [3:0][bpms_pkg::CSR_DATA_BITS-1:0]        words_ff, words_in;
   bpms_pkg::needle_class_type                     class_ff, class_in;

   logic [bpms_pkg::NEEDLE_SLOTS-1:0][7:0]         needle_bytes;
   logic [bpms_pkg::LEN_BITS-1:0]                  len_clip;
   logic [7:0]                                     second_byte;
   logic                                           two_values;

   // register writes
   always_comb begin
      length_in = length_ff;
      words_in  = words_ff;
      if (csr_write) begin
         case (csr_index)
            bpms_pkg::CSR_NEEDLE_LENGTH: length_in = csr_data[bpms_pkg::LEN_BITS-1:0];
            bpms_pkg::CSR_NEEDLE_WORD_0: words_in[0] = csr_data;
            bpms_pkg::CSR_NEEDLE_WORD_1: words_in[1] = csr_data;
            bpms_pkg::CSR_NEEDLE_WORD_2: words_in[2] = csr_data;
            bpms_pkg::CSR_NEEDLE_WORD_3: words_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   // byte k of the needle sits at bits 8k of the packed words
   assign needle_bytes = words_ff;

   // classification of the current needle
   always_comb begin
      len_clip = (length_ff > LEN_LIMIT) ? LEN_LIMIT : length_ff;

      // second value: lowest slot that differs from byte 0
      second_byte = needle_bytes[0];
      for (int k = bpms_pkg::NEEDLE_SLOTS - 1; k > 0; k--) begin
         if (bpms_pkg::LEN_BITS'(k) < len_clip && needle_bytes[k] != needle_bytes[0]) begin
            second_byte = needle_bytes[k];
         end
      end

      class_in.all_same = 1'b1;
      two_values        = 1'b1;
      for (int k = 0; k < bpms_pkg::NEEDLE_SLOTS; k++) begin
         if (bpms_pkg::LEN_BITS'(k) < len_clip) begin
            if (needle_bytes[k] != needle_bytes[0]) begin
               class_in.all_same = 1'b0;
               if (needle_bytes[k] != second_byte) begin
                  two_values = 1'b0;
               end
            end
         end
      end

      class_in.len         = len_clip;
      class_in.low_entropy = (len_clip >= bpms_pkg::LOW_ENTROPY_MIN_LEN) && two_values;
      class_in.first_byte  = needle_bytes[0];

      for (int j = 0; j < bpms_pkg::NEEDLE_SLOTS; j++) begin
         if (bpms_pkg::LEN_BITS'(j) < len_clip) begin
            class_in.aligned[j] =
               needle_bytes[5'(len_clip - bpms_pkg::LEN_BITS'(j) - 6'd1)];
         end else begin
            class_in.aligned[j] = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff            <= '0;
         words_ff             <= '0;
         class_ff.len         <= '0;
         class_ff.all_same    <= 1'b1;
         class_ff.low_entropy <= 1'b0;
         class_ff.first_byte  <= '0;
         class_ff.aligned     <= '0;
      end else begin
         length_ff <= length_in;
         words_ff  <= words_in;
         class_ff  <= class_in;
      end
   end

   assign needle_class = class_ff;

endmodule

`default_nettype wire

/* rtl/bpms_scan.sv */
`default_nettype none

module bpms_scan #(
   parameter int MAX_NEEDLE_BYTES = 32,
   parameter int OFFSET_BITS      = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire logic [7:0]                          data_byte,
   input  wire logic                                buffer_end,
   input  wire bpms_pkg::needle_class_type          needle_class,
   output logic                                     hit,
   output logic [bpms_pkg::MATCH_BITS-1:0]          match_offset
);

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   logic [MAX_NEEDLE_BYTES-1:0][7:0]   window_ff, window_in;
   logic [OFFSET_BITS-1:0]             position_ff, position_in;
   logic [OFFSET_BITS-1:0]             earliest_ff, earliest_in;
   logic                               skipping_ff, skipping_in;

   logic [MAX_NEEDLE_BYTES-1:0][7:0]   shifted;
   logic [OFFSET_BITS-1:0]             len_wide;
   logic [OFFSET_BITS-1:0]             position_next;
   logic [OFFSET_BITS-1:0]             start;
   logic [OFFSET_BITS-1:0]             start_next;
   logic [OFFSET_BITS-1:0]             earliest_mid;
   logic                               skipping_mid;
   logic                               run_continues;
   logic                               bytes_equal;
   logic                               enough_bytes;
   logic [OFFSET_BITS+bpms_pkg::MATCH_BITS-1:0] start_wide;

   always_comb begin
      // newest byte enters slot 0
      shifted[0] = data_byte;
      for (int j = 1; j < MAX_NEEDLE_BYTES; j++) begin
         shifted[j] = window_ff[j-1];
      end

      bytes_equal = 1'b1;
      for (int j = 0; j < MAX_NEEDLE_BYTES; j++) begin
         if (bpms_pkg::LEN_BITS'(j) < needle_class.len && shifted[j] != needle_class.aligned[j]) begin
            bytes_equal = 1'b0;
         end
      end

      len_wide      = {{(OFFSET_BITS-bpms_pkg::LEN_BITS){1'b0}}, needle_class.len};
      position_next = (position_ff == OFFSET_MAX) ? position_ff : position_ff + 1'b1;
      enough_bytes  = (needle_class.len != '0) && (position_ff >= len_wide - 1'b1);
      start         = position_ff - (len_wide - 1'b1);
      start_next    = (start == OFFSET_MAX) ? start : start + 1'b1;

      // run skip after an all-same match
      run_continues = (needle_class.len != '0) && needle_class.all_same
                      && (data_byte == needle_class.first_byte);
      earliest_mid  = (skipping_ff && run_continues) ? position_next : earliest_ff;
      skipping_mid  = skipping_ff && run_continues;

      hit = enough_bytes && (start >= earliest_mid) && bytes_equal;

      earliest_in = earliest_mid;
      skipping_in = skipping_mid;
      if (hit) begin
         if (needle_class.all_same) begin
            earliest_in = position_next;
            skipping_in = 1'b1;
         end else if (needle_class.low_entropy) begin
            earliest_in = position_next;
         end else begin
            earliest_in = start_next;
         end
      end

      window_in   = shifted;
      position_in = position_next;
      if (buffer_end) begin
         window_in   = '0;
         position_in = '0;
         earliest_in = '0;
         skipping_in = 1'b0;
      end

      start_wide   = {{bpms_pkg::MATCH_BITS{1'b0}}, start};
      match_offset = start_wide[bpms_pkg::MATCH_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         position_ff <= '0;
         earliest_ff <= '0;
         skipping_ff <= 1'b0;
      end else if (step) begin
         window_ff   <= window_in;
         position_ff <= position_in;
         earliest_ff <= earliest_in;
         skipping_ff <= skipping_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/byte_pattern_match_scanner_core.sv */
`default_nettype none

// byte pattern scanner: reports the start offset of needle matches in a byte stream
// - csr channel: csr_index selects needle length (0) or needle words 0..3 (1..4),
//   csr_data carries the value; csr_ready is high outside reset, write only while idle
// - req channel: one buffer byte per request, req_buffer_end marks the last byte
//   of a buffer, after which offset, window and resume state restart
// - rsp channel: rsp_match_offset is the offset of a match start within the buffer;
//   a request gives at most one response
// - a request waits in the input register, its match in the response register
// - throughput: one request per cycle while not stalled; the whole window is
//   compared at once against a needle image registered after each csr write
// - a request that finds no match produces no response
// - when the receiver stalls, the response register holds and the input register
//   keeps one more request; req_ready drops only when both are occupied
// - reset (synchronous, active high) clears needle, window, offset and resume state;
//   csr_ready and req_ready stay low while reset is high
module byte_pattern_match_scanner_core #(
   parameter int MAX_NEEDLE_BYTES = 32,
   parameter int OFFSET_BITS      = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [bpms_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bpms_pkg::CSR_DATA_BITS-1:0]    csr_data,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [7:0]                            req_data_byte,
   input  wire logic                                  req_buffer_end,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [bpms_pkg::MATCH_BITS-1:0]            rsp_match_offset
);

   bpms_pkg::needle_class_type               needle_class;

   // input register
   logic                                     in_valid_ff, in_valid_in;
   logic [7:0]                               in_byte_ff, in_byte_in;
   logic                                     in_end_ff, in_end_in;

   // response register
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [bpms_pkg::MATCH_BITS-1:0]          rsp_offset_ff, rsp_offset_in;

   logic                                     step;
   logic                                     hit;
   logic [bpms_pkg::MATCH_BITS-1:0]          match_offset;
   logic                                     req_take;

   assign csr_ready = !reset;

   bpms_needle #(
      .MAX_NEEDLE_BYTES (MAX_NEEDLE_BYTES)
   ) u_needle (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .needle_class (needle_class)
   );

   // the registered request advances when the response slot is free or draining
   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!in_valid_ff || step);
   assign req_take  = req_valid && req_ready;

   bpms_scan #(
      .MAX_NEEDLE_BYTES (MAX_NEEDLE_BYTES),
      .OFFSET_BITS      (OFFSET_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .buffer_end   (in_end_ff),
      .needle_class (needle_class),
      .hit          (hit),
      .match_offset (match_offset)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_end_in   = req_buffer_end;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      if (step) begin
         // slot is empty or being taken this cycle
         rsp_valid_in = hit;
         if (hit) begin
            rsp_offset_in = match_offset;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff    <= in_byte_in;
      in_end_ff     <= in_end_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_offset = rsp_offset_ff;

   // a held response is never overwritten by the scan stage
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !step)
      else $error("scan step while response stalled");

   // a taken request always lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted request lost");

   // a new response only appears after a scan step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step))
      else $error("response without scan step");

   // an empty input register never stalls the request side
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("request stalled with empty input register");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   // offsets stop counting at the top of the 32-bit range
   localparam longint unsigned OFFSET_LIMIT = 64'hFFFF_FFFF;
   // cycles allowed after the last match for a request still in the pipe
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_REQUESTS = 510;
   localparam int CYCLE_LIMIT = 300000;

   typedef enum {NEEDLE_EMPTY, NEEDLE_MIXED, NEEDLE_REPEATED, NEEDLE_TWO_VALUE} needle_kind_type;

   // tracks needle registers and scan state, queues match offsets per request
   class match_scoreboard_type;
      logic [5:0]      length_reg;
      logic [63:0]     needle_word [4];
      logic [7:0]      recent_bytes [32];
      longint unsigned stream_offset;
      longint unsigned resume_floor;
      bit              run_skip;
      logic [31:0]     expected_offsets [$];
      int              failures;
      int              matched;

      function new();
         length_reg = '0;
         foreach (needle_word[k]) needle_word[k] = '0;
         foreach (recent_bytes[k]) recent_bytes[k] = '0;
         stream_offset = 0;
         resume_floor = 0;
         run_skip = 0;
         failures = 0;
         matched = 0;
      endfunction

      function void set_register(logic [bpms_pkg::CSR_INDEX_BITS-1:0] idx, logic [63:0] value);
         case (idx)
            bpms_pkg::CSR_NEEDLE_LENGTH: length_reg = value[5:0];
            bpms_pkg::CSR_NEEDLE_WORD_0: needle_word[0] = value;
            bpms_pkg::CSR_NEEDLE_WORD_1: needle_word[1] = value;
            bpms_pkg::CSR_NEEDLE_WORD_2: needle_word[2] = value;
            bpms_pkg::CSR_NEEDLE_WORD_3: needle_word[3] = value;
            default: ;
         endcase
      endfunction

      function logic [7:0] needle_at(int unsigned k);
         return needle_word[k / 8][(k % 8) * 8 +: 8];
      endfunction

      function longint unsigned bump(longint unsigned v);
         return (v < OFFSET_LIMIT) ? v + 1 : OFFSET_LIMIT;
      endfunction

      function int pending();
         return expected_offsets.size();
      endfunction

      function void note_request(logic [7:0] data, logic last);
         int unsigned     used, distinct, k;
         logic [7:0]      first_val, second_val, c;
         bit              uniform, sparse, hit;
         longint unsigned here, start;
         used = (length_reg > bpms_pkg::NEEDLE_SLOTS) ? bpms_pkg::NEEDLE_SLOTS : length_reg;
         here = stream_offset;
         for (k = 31; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
         recent_bytes[0] = data;
         // classify the needle from the registers as they stand now
         uniform = 1;
         distinct = 0;
         first_val = '0;
         second_val = '0;
         for (k = 0; k < used; k++) begin
            c = needle_at(k);
            if (distinct == 0) begin
               first_val = c;
               distinct = 1;
            end else if (c != first_val) begin
               uniform = 0;
               if (distinct == 1) begin
                  second_val = c;
                  distinct = 2;
               end else if (c != second_val) begin
                  distinct = 3;
               end
            end
         end
         sparse = (used >= bpms_pkg::LOW_ENTROPY_MIN_LEN) && (distinct <= 2);
         if (run_skip) begin
            if (used > 0 && uniform && data == first_val) resume_floor = bump(here);
            else run_skip = 0;
         end
         if (used > 0 && here + 1 >= used) begin
            start = here + 1 - used;
            hit = (start >= resume_floor);
            for (k = 0; hit && k < used; k++)
               if (recent_bytes[used - 1 - k] != needle_at(k)) hit = 0;
            if (hit) begin
               expected_offsets = {expected_offsets, start[31:0]};
               if (uniform) begin
                  resume_floor = bump(here);
                  run_skip = 1;
               end else if (sparse) begin
                  resume_floor = bump(here);
               end else begin
                  resume_floor = bump(start);
               end
            end
         end
         if (last) begin
            foreach (recent_bytes[j]) recent_bytes[j] = '0;
            stream_offset = 0;
            resume_floor = 0;
            run_skip = 0;
         end else begin
            stream_offset = bump(here);
         end
      endfunction

      function void check_response(logic [31:0] got);
         logic [31:0] want;
         if (expected_offsets.size() == 0) begin
            failures++;
            $display("%0t: match response with none expected, actual offset %0d", $time, got);
         end else begin
            want = expected_offsets.pop_front();
            matched++;
            if (got !== want) begin
               failures++;
               $display("%0t: match offset mismatch, expected %0d, actual %0d",
                        $time, want, got);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [bpms_pkg::CSR_INDEX_BITS-1:0] csr_index = bpms_pkg::CSR_NEEDLE_LENGTH;
   logic [bpms_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [7:0]                          req_data_byte = '0;
   logic                                req_buffer_end = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [bpms_pkg::MATCH_BITS-1:0]     rsp_match_offset;

   match_scoreboard_type matcher = new();

   // needle as the stimulus sees it, span is the clipped length in use
   logic [7:0] needle_image [32];
   int         needle_span = 0;
   logic [7:0] stream_bytes [$];
   bit         steady_traffic = 1'b0;
   int         requests_sent = 0;
   int         settings_loaded = 0;
   int         cycle_count = 0;
   int         ready_hold = 0;

   byte_pattern_match_scanner_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_buffer_end   (req_buffer_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_match_offset (rsp_match_offset)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one, none in steady phases
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_traffic || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // receiver side: ready or stalled spans of random length, mostly ready
   always @(posedge clock) begin
      if (steady_traffic) begin
         rsp_ready <= 1'b1;
         ready_hold = 0;
      end else if (ready_hold == 0) begin
         rsp_ready <= ($urandom_range(0, 9) < 7);
         ready_hold = pick_gap() + 1;
      end else begin
         ready_hold--;
      end
   end

   // every accepted response goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) matcher.check_response(rsp_match_offset);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("byte_pattern_match_scanner_core verification failed");
         $finish;
      end
   end

   // one request: optional gap, then hold valid until the handshake
   task automatic send_byte(logic [7:0] data, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_buffer_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      matcher.note_request(data, last);
   endtask

   // push the queued buffer, end flag on the final byte only when asked
   task automatic send_buffer(bit with_end);
      int k;
      for (k = 0; k < stream_bytes.size(); k++)
         send_byte(stream_bytes[k], with_end && (k == stream_bytes.size() - 1));
   endtask

   // wait for all matches, then let a trailing no-match request drain
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (matcher.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write length and all four needle words from the current image
   task automatic load_needle(logic [5:0] len_field);
      logic [bpms_pkg::CSR_INDEX_BITS-1:0] reg_index [5];
      logic [63:0]                         reg_value [5];
      int                                  w, k;
      reg_index = '{bpms_pkg::CSR_NEEDLE_LENGTH, bpms_pkg::CSR_NEEDLE_WORD_0,
                    bpms_pkg::CSR_NEEDLE_WORD_1, bpms_pkg::CSR_NEEDLE_WORD_2,
                    bpms_pkg::CSR_NEEDLE_WORD_3};
      reg_value[0] = {58'd0, len_field};
      for (w = 0; w < 4; w++)
         for (k = 0; k < 8; k++) reg_value[w + 1][k * 8 +: 8] = needle_image[w * 8 + k];
      for (w = 0; w < 5; w++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_index[w];
         csr_data <= reg_value[w];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         matcher.set_register(reg_index[w], reg_value[w]);
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // fill the needle image; bytes past the span are random filler
   function automatic logic [5:0] make_needle(needle_kind_type kind, int span, bit oversize);
      logic [7:0] first_val, second_val;
      logic [7:0] pick [4];
      int         k;
      first_val = 8'($urandom_range(0, 255));
      second_val = first_val ^ 8'($urandom_range(1, 255));
      foreach (pick[j]) pick[j] = 8'($urandom_range(0, 255));
      for (k = 0; k < 32; k++) begin
         if (k >= span) begin
            needle_image[k] = 8'($urandom_range(0, 255));
         end else begin
            case (kind)
               NEEDLE_REPEATED:  needle_image[k] = first_val;
               NEEDLE_TWO_VALUE: needle_image[k] = $urandom_range(0, 1) ? second_val : first_val;
               default: needle_image[k] = ($urandom_range(0, 2) == 0) ?
                                          8'($urandom_range(0, 255)) : pick[$urandom_range(0, 3)];
            endcase
         end
      end
      needle_span = span;
      // lengths above the slot count are clipped by the block
      return oversize ? 6'($urandom_range(33, 63)) : 6'(span);
   endfunction

   // add one byte to the end of the buffer under construction
   function automatic void append_stream(logic [7:0] b);
      stream_bytes = {stream_bytes, b};
   endfunction

   // a buffer made mostly of needle copies, broken copies and runs of the first byte
   function automatic void build_buffer();
      int target, piece, n, k;
      stream_bytes.delete();
      if (needle_span > 1 && $urandom_range(0, 9) == 0)
         target = $urandom_range(1, needle_span - 1);    // shorter than the needle
      else
         target = $urandom_range(1, 3 * needle_span + 12);
      while (stream_bytes.size() < target) begin
         piece = $urandom_range(0, 99);
         if (needle_span == 0 || piece >= 85) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
               case ($urandom_range(0, 3))
                  0: append_stream(8'h00);
                  1: append_stream(8'hFF);
                  default: append_stream(8'($urandom_range(0, 255)));
               endcase
            end
         end else if (piece < 45) begin
            for (k = 0; k < needle_span; k++) append_stream(needle_image[k]);
         end else if (piece < 60) begin
            n = $urandom_range(1, needle_span);
            for (k = 0; k < n; k++) append_stream(needle_image[k]);
         end else if (piece < 72) begin
            n = $urandom_range(1, needle_span + 3);
            for (k = 0; k < n; k++) append_stream(needle_image[0]);
         end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
               append_stream(needle_image[$urandom_range(0, needle_span - 1)]);
         end
      end
      while (stream_bytes.size() > target) void'(stream_bytes.pop_back());
   endfunction

   initial begin
      needle_kind_type kind;
      int              span, r, phase, random_sent, phase_budget, phase_sent;
      bit              oversize;
      logic [5:0]      len_field;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty needle straight out of reset, zero window must not match
      stream_bytes = '{8'h00, 8'hFF};
      send_buffer(1);

      // directed: repeated-byte needle, the run after a match is skipped
      settle();
      len_field = make_needle(NEEDLE_REPEATED, 2, 0);
      needle_image[0] = 8'h41;
      needle_image[1] = 8'h41;
      load_needle(len_field);
      stream_bytes = '{8'h41, 8'h41, 8'h41, 8'h41, 8'h7E, 8'h41, 8'h41};
      send_buffer(0);

      // directed: needle swapped mid-buffer while a run skip is pending
      settle();
      len_field = make_needle(NEEDLE_MIXED, 3, 0);
      needle_image[0] = 8'h61;
      needle_image[1] = 8'h62;
      needle_image[2] = 8'h61;
      load_needle(len_field);
      stream_bytes = '{8'h61, 8'h62, 8'h61};
      send_buffer(1);
      // buffer shorter than the needle
      stream_bytes = '{8'h61, 8'h62};
      send_buffer(1);
      // overlapping matches
      stream_bytes = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
      send_buffer(1);

      // random phases: first four pin the length extremes and the needle classes
      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_REQUESTS) begin
         settle();
         case (phase)
            0: begin kind = NEEDLE_REPEATED;  span = 32; oversize = 1; end
            1: begin kind = NEEDLE_MIXED;     span = 1;  oversize = 0; end
            2: begin kind = NEEDLE_TWO_VALUE; span = 16; oversize = 0; end
            3: begin kind = NEEDLE_EMPTY;     span = 0;  oversize = 0; end
            default: begin
               r = $urandom_range(0, 99);
               kind = (r < 45) ? NEEDLE_MIXED : (r < 70) ? NEEDLE_REPEATED :
                      (r < 92) ? NEEDLE_TWO_VALUE : NEEDLE_EMPTY;
               case (kind)
                  NEEDLE_MIXED: span = ($urandom_range(0, 3) != 0) ?
                                       $urandom_range(1, 6) : $urandom_range(7, 32);
                  NEEDLE_REPEATED:  span = $urandom_range(1, 32);
                  NEEDLE_TWO_VALUE: span = $urandom_range(14, 32);
                  default:          span = 0;
               endcase
               oversize = (span == 32) && $urandom_range(0, 1);
            end
         endcase
         len_field = make_needle(kind, span, oversize);
         load_needle(len_field);
         steady_traffic = ($urandom_range(0, 3) == 0);
         phase_budget = $urandom_range(40, 90);
         phase_sent = 0;
         while (phase_sent < phase_budget) begin
            build_buffer();
            phase_sent += stream_bytes.size();
            // sometimes leave the last buffer open across the next needle change
            send_buffer(!(phase_sent >= phase_budget && $urandom_range(0, 3) == 0));
         end
         random_sent += phase_sent;
         phase++;
      end

      settle();
      $display("scanned %0d request bytes, checked %0d match offsets", requests_sent,
               matcher.matched);
      $display("needle settings loaded: %0d, including empty, clipped and repeated-byte needles",
               settings_loaded);
      if (matcher.failures == 0 && matcher.pending() == 0) begin
         $display("byte_pattern_match_scanner_core verification clean");
      end else begin
         $display("byte_pattern_match_scanner_core verification failed");
      end
      $finish;
   end

endmodule
